// File: hw/rtl/bcpa_pkg.sv
// Shared types and constants for the bitmap contiguous page allocator.
`default_nettype none

package bcpa_pkg;

  localparam int unsigned NUM_PAGES_DEF = 4096;
  localparam int unsigned MAX_RUN_DEF   = 63;

  localparam int unsigned PAGE_W      = 12;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned ZONE_W      = 2;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned WIDX_W      = 6;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEN  = 2'd1,
    ST_BAD_ZONE = 2'd2,
    ST_NO_RUN   = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ZONE_LOWMEM  = 2'd0,
    ZONE_GENERAL = 2'd1,
    ZONE_UPPER   = 2'd2,
    ZONE_INVALID = 2'd3
  } zone_e;

  typedef enum logic [2:0] {
    CFG_DMA_LO    = 3'd0,
    CFG_DMA_HI    = 3'd1,
    CFG_NORMAL_LO = 3'd2,
    CFG_NORMAL_HI = 3'd3,
    CFG_UPPER_LO  = 3'd4,
    CFG_UPPER_HI  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic              hit;
    logic [WIDX_W-1:0] pos;
  } hit_t;

endpackage

`default_nettype wire

// File: hw/rtl/bitmap_contiguous_page_allocator_top.sv
// Top level of the bitmap contiguous page allocator: request control and result register.
//
// The allocator keeps one bit per page (set means used) in a 64-bit-wide synchronous
// memory and serves one request at a time. All pages read as used after reset, so
// software frees the usable pages first. An allocate scans the bitmap words of the
// zone range one per cycle through the single memory read port; when the run reaches
// back into the previous word, that word is marked in a further state. A free touches
// at most two words. A new request is taken while the last result still waits on the
// output register.
`default_nettype none

module bitmap_contiguous_page_allocator_top #(
  parameter int unsigned NUM_PAGES = bcpa_pkg::NUM_PAGES_DEF,
  parameter int unsigned MAX_RUN   = bcpa_pkg::MAX_RUN_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // zone_class [1:0], run_length [7:2], start_page [19:8], zero fill
  input  wire logic [bcpa_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // cmd [0]
  input  wire logic [0:0]                        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // status [1:0], page_index [13:2], zero fill
  output logic [bcpa_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  input  wire logic                              cfg_we_i,
  input  wire logic [bcpa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [bcpa_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned MAP_WORDS = (NUM_PAGES + 63) / 64;
  localparam int unsigned MEM_WORDS = (MAP_WORDS < 64) ? MAP_WORDS : 64;
  localparam int unsigned AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int unsigned PW        = bcpa_pkg::PAGE_W;
  localparam int unsigned WW        = bcpa_pkg::WIDX_W;
  localparam int unsigned LW        = bcpa_pkg::LEN_W;
  localparam int unsigned DW        = bcpa_pkg::WORD_BITS;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_FREE0     = 6'b000010,
    S_FREE1     = 6'b000100,
    S_SCAN      = 6'b001000,
    S_MARK_PREV = 6'b010000,
    S_DONE      = 6'b100000
  } state_e;

  function automatic logic [DW-1:0] page_mask(input logic [WW-1:0] w);
    logic [DW-1:0] m;
    for (int b = 0; b < int'(DW); b++) begin
      m[b] = ({20'd0, w, 6'(b)} < NUM_PAGES);
    end
    return m;
  endfunction

  function automatic logic word_ok(input logic [WW-1:0] w);
    return (32'(w) < MEM_WORDS);
  endfunction

  // Request fields.
  bcpa_pkg::cmd_e  in_cmd;
  bcpa_pkg::zone_e in_zone;
  logic [LW-1:0]   in_len;
  logic [PW-1:0]   in_start;

  assign in_cmd   = bcpa_pkg::cmd_e'(s_axis_tuser[0]);
  assign in_zone  = bcpa_pkg::zone_e'(s_axis_tdata[1:0]);
  assign in_len   = s_axis_tdata[7:2];
  assign in_start = s_axis_tdata[19:8];

  // Zone range registers.
  logic [PW-1:0] dma_lo_q, dma_hi_q, normal_lo_q, normal_hi_q, upper_lo_q, upper_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dma_lo_q    <= '0;
      dma_hi_q    <= '0;
      normal_lo_q <= '0;
      normal_hi_q <= '1;
      upper_lo_q  <= '0;
      upper_hi_q  <= '1;
    end else if (cfg_we_i) begin
      case (bcpa_pkg::cfg_idx_e'(cfg_idx_i))
        bcpa_pkg::CFG_DMA_LO:    dma_lo_q    <= cfg_data_i;
        bcpa_pkg::CFG_DMA_HI:    dma_hi_q    <= cfg_data_i;
        bcpa_pkg::CFG_NORMAL_LO: normal_lo_q <= cfg_data_i;
        bcpa_pkg::CFG_NORMAL_HI: normal_hi_q <= cfg_data_i;
        bcpa_pkg::CFG_UPPER_LO:  upper_lo_q  <= cfg_data_i;
        bcpa_pkg::CFG_UPPER_HI:  upper_hi_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control and working registers.
  state_e              state_q, state_d;
  bcpa_pkg::cmd_e      cmd_q, cmd_d;
  logic [LW-1:0]       len_q, len_d;
  logic [PW-1:0]       lo_q, lo_d, hi_q, hi_d;
  logic [WW-1:0]       w_q, w_d;
  logic [DW-1:0]       prev_free_q, prev_free_d;
  logic [DW-1:0]       prev_raw_q, prev_raw_d;
  logic [DW-1:0]       mask_lo_q, mask_lo_d;
  logic [DW-1:0]       mask_hi_q, mask_hi_d;
  bcpa_pkg::status_e   res_status_q, res_status_d;
  logic [PW-1:0]       res_page_q, res_page_d;
  logic                out_valid_q, out_valid_d;
  bcpa_pkg::status_e   out_status_q, out_status_d;
  logic [PW-1:0]       out_page_q, out_page_d;

  // Memory access.
  logic            rd_req, mem_re, mem_we;
  logic [WW-1:0]   rd_word, wr_word;
  logic [DW-1:0]   mem_wdata, cur_raw;

  // Scan datapath.
  logic [PW-1:0]       sel_lo, sel_hi;
  logic                len_bad;
  logic [DW-1:0]       lo_mask, hi_mask, cur_free;
  bcpa_pkg::hit_t      hit;
  logic [6:0]          start_win;
  logic [2*DW-1:0]     run_mask, clr_mask;
  logic [PW:0]         hit_page;

  bcpa_bitmap_mem #(
    .WORDS (MEM_WORDS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (mem_re),
    .raddr_i (rd_word[AW-1:0]),
    .we_i    (mem_we),
    .waddr_i (wr_word[AW-1:0]),
    .wdata_i (mem_wdata),
    .rdata_o (cur_raw)
  );

  bcpa_run_finder u_finder (
    .prev_free_i  (prev_free_q),
    .cur_free_i   (cur_free),
    .run_length_i (len_q),
    .hit_o        (hit)
  );

  always_comb begin
    case (in_zone)
      bcpa_pkg::ZONE_LOWMEM: begin
        sel_lo = dma_lo_q;
        sel_hi = dma_hi_q;
      end
      bcpa_pkg::ZONE_GENERAL: begin
        sel_lo = normal_lo_q;
        sel_hi = normal_hi_q;
      end
      default: begin
        sel_lo = upper_lo_q;
        sel_hi = upper_hi_q;
      end
    endcase
  end

  assign len_bad  = (in_len == '0) || (7'(in_len) > 7'(MAX_RUN));
  assign clr_mask = ((128'd1 << in_len) - 128'd1) << in_start[5:0];

  assign lo_mask  = (w_q == lo_q[PW-1:6]) ? ~((64'd1 << lo_q[5:0]) - 64'd1) : '1;
  assign hi_mask  = (w_q == hi_q[PW-1:6]) ? ((64'd2 << hi_q[5:0]) - 64'd1) : '1;
  assign cur_free = ~cur_raw & lo_mask & hi_mask & page_mask(w_q);

  assign start_win = 7'd65 + {1'b0, hit.pos} - {1'b0, len_q};
  assign run_mask  = ((128'd1 << len_q) - 128'd1) << start_win;
  assign hit_page  = 13'({w_q, 6'd0}) + 13'(hit.pos) + 13'd1 - 13'(len_q);

  assign mem_re = rd_req && word_ok(rd_word);

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    len_d        = len_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    w_d          = w_q;
    prev_free_d  = prev_free_q;
    prev_raw_d   = prev_raw_q;
    mask_lo_d    = mask_lo_q;
    mask_hi_d    = mask_hi_q;
    res_status_d = res_status_q;
    res_page_d   = res_page_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_page_d   = out_page_q;
    rd_req       = 1'b0;
    rd_word      = '0;
    mem_we       = 1'b0;
    wr_word      = w_q;
    mem_wdata    = cur_raw;
    s_axis_tready = 1'b0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_d        = in_cmd;
          len_d        = in_len;
          lo_d         = sel_lo;
          hi_d         = sel_hi;
          res_page_d   = '0;
          res_status_d = bcpa_pkg::ST_OK;
          prev_free_d  = '0;
          state_d      = S_DONE;
          if (len_bad) begin
            res_status_d = bcpa_pkg::ST_BAD_LEN;
          end else if (in_cmd == bcpa_pkg::CMD_FREE) begin
            w_d       = in_start[PW-1:6];
            mask_lo_d = clr_mask[DW-1:0];
            mask_hi_d = clr_mask[2*DW-1:DW];
            rd_req    = 1'b1;
            rd_word   = in_start[PW-1:6];
            state_d   = S_FREE0;
          end else if (in_zone == bcpa_pkg::ZONE_INVALID) begin
            res_status_d = bcpa_pkg::ST_BAD_ZONE;
          end else if (sel_lo > sel_hi) begin
            res_status_d = bcpa_pkg::ST_NO_RUN;
          end else begin
            w_d     = sel_lo[PW-1:6];
            rd_req  = 1'b1;
            rd_word = sel_lo[PW-1:6];
            state_d = S_SCAN;
          end
        end
      end

      S_FREE0: begin
        mem_we    = word_ok(w_q);
        mem_wdata = cur_raw & ~(mask_lo_q & page_mask(w_q));
        if ((|mask_hi_q) && (w_q != '1)) begin
          w_d     = w_q + WW'(1);
          rd_req  = 1'b1;
          rd_word = w_q + WW'(1);
          state_d = S_FREE1;
        end else begin
          state_d = S_DONE;
        end
      end

      S_FREE1: begin
        mem_we    = word_ok(w_q);
        mem_wdata = cur_raw & ~(mask_hi_q & page_mask(w_q));
        state_d   = S_DONE;
      end

      S_SCAN: begin
        if (hit.hit) begin
          mem_we       = 1'b1;
          mem_wdata    = cur_raw | run_mask[2*DW-1:DW];
          mask_lo_d    = run_mask[DW-1:0];
          res_page_d   = hit_page[PW-1:0];
          res_status_d = bcpa_pkg::ST_OK;
          state_d      = (|run_mask[DW-1:0]) ? S_MARK_PREV : S_DONE;
        end else if (w_q == hi_q[PW-1:6]) begin
          res_status_d = bcpa_pkg::ST_NO_RUN;
          res_page_d   = '0;
          state_d      = S_DONE;
        end else begin
          prev_free_d = cur_free;
          prev_raw_d  = cur_raw;
          w_d         = w_q + WW'(1);
          rd_req      = 1'b1;
          rd_word     = w_q + WW'(1);
        end
      end

      S_MARK_PREV: begin
        mem_we    = 1'b1;
        wr_word   = w_q - WW'(1);
        mem_wdata = prev_raw_q | mask_lo_q;
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_page_d   = res_page_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    len_q        <= len_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    w_q          <= w_d;
    prev_free_q  <= prev_free_d;
    prev_raw_q   <= prev_raw_d;
    mask_lo_q    <= mask_lo_d;
    mask_hi_q    <= mask_hi_d;
    res_status_q <= res_status_d;
    res_page_q   <= res_page_d;
    out_status_q <= out_status_d;
    out_page_q   <= out_page_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_page_q, out_status_q};

  function automatic logic len_bad_q_chk();
    return (len_q == '0) || (7'(len_q) > 7'(MAX_RUN));
  endfunction

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (w_q >= lo_q[PW-1:6]) && (w_q <= hi_q[PW-1:6]))
    else $error("scan word left the zone range");

  a_alloc_page_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && (cmd_q == bcpa_pkg::CMD_ALLOC) && !len_bad_q_chk()
      && (res_status_q == bcpa_pkg::ST_OK)
    |-> (res_page_q >= lo_q) && (res_page_q <= hi_q))
    else $error("allocated run starts outside the zone range");

  a_error_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && (res_status_q != bcpa_pkg::ST_OK) |-> (res_page_q == '0))
    else $error("failed request carries a nonzero page index");

  a_no_write_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) || (state_q == S_DONE) |-> !mem_we)
    else $error("bitmap written outside a request");

  a_hit_writes_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && hit.hit |=> (state_q == S_MARK_PREV) || (state_q == S_DONE))
    else $error("run found but marking did not follow");

endmodule

`default_nettype wire

// File: hw/rtl/bcpa_bitmap_mem.sv
// Page bitmap memory with registered read data and per-word written flags.
`default_nettype none

module bcpa_bitmap_mem #(
  parameter int unsigned WORDS = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           re_i,
  input  wire logic [AW-1:0]                  raddr_i,
  input  wire logic                           we_i,
  input  wire logic [AW-1:0]                  waddr_i,
  input  wire logic [bcpa_pkg::WORD_BITS-1:0] wdata_i,
  output logic      [bcpa_pkg::WORD_BITS-1:0] rdata_o
);

  logic [bcpa_pkg::WORD_BITS-1:0] mem_q [WORDS];
  logic [bcpa_pkg::WORD_BITS-1:0] rdata_q;
  logic [WORDS-1:0]               written_q;
  logic                           rwritten_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // A word never written since reset reads as every page used.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q  <= '0;
      rwritten_q <= 1'b0;
    end else begin
      if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rwritten_q <= written_q[raddr_i];
      end
    end
  end

  assign rdata_o = rwritten_q ? rdata_q : '1;

endmodule

`default_nettype wire

// File: hw/rtl/bcpa_run_finder.sv
// Finds the lowest run end inside the current word over a two-word free window.
`default_nettype none

module bcpa_run_finder (
  input  wire logic [bcpa_pkg::WORD_BITS-1:0] prev_free_i,
  input  wire logic [bcpa_pkg::WORD_BITS-1:0] cur_free_i,
  input  wire logic [bcpa_pkg::LEN_W-1:0]     run_length_i,
  output bcpa_pkg::hit_t                      hit_o
);

  localparam int unsigned WIN_W = 2 * bcpa_pkg::WORD_BITS;

  logic [WIN_W-1:0]               avail [bcpa_pkg::LEN_W];
  logic [WIN_W-1:0]               win;
  logic [bcpa_pkg::WORD_BITS-1:0] ends;
  logic [bcpa_pkg::WORD_BITS-1:0] first;
  logic [bcpa_pkg::WIDX_W-1:0]    pos;

  // Bit j of avail[k] is set when the 2**k pages ending at j are all free.
  always_comb begin
    avail[0] = {cur_free_i, prev_free_i};
    for (int k = 1; k < int'(bcpa_pkg::LEN_W); k++) begin
      avail[k] = avail[k-1] & (avail[k-1] << (1 << (k - 1)));
    end
    win = '1;
    for (int k = 0; k < int'(bcpa_pkg::LEN_W); k++) begin
      if (run_length_i[k]) begin
        win = (win << (1 << k)) & avail[k];
      end
    end
    ends  = win[WIN_W-1:bcpa_pkg::WORD_BITS];
    first = ends & (~ends + 64'd1);
    pos   = '0;
    for (int b = 0; b < int'(bcpa_pkg::WORD_BITS); b++) begin
      if (first[b]) begin
        pos = pos | bcpa_pkg::WIDX_W'(b);
      end
    end
    hit_o.hit = |ends;
    hit_o.pos = pos;
  end

endmodule

`default_nettype wire
